// File: rtl/tod_pkg.sv
// shared types and constants of the trajectory oscillation detector
`default_nettype none
package tod_pkg;

  // fixed field widths
  localparam int THR_W   = 21;
  localparam int LIM_W   = 8;
  localparam int RUN_W   = 8;

  // multiplier digit and threshold operand sizes
  localparam int DIGIT_W = 16;
  localparam int TMAG_W  = 21;
  localparam int T2_W    = 41;
  localparam int ND_T    = 2;
  localparam int ND_T2   = 3;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_OSC_LIMIT = 1'b1;

  // multiply-accumulate operations, in issue order
  typedef logic [3:0] op_t;
  localparam op_t OP_PP_X = 4'd0;
  localparam op_t OP_PP_Y = 4'd1;
  localparam op_t OP_PP_Z = 4'd2;
  localparam op_t OP_PC_X = 4'd3;
  localparam op_t OP_PC_Y = 4'd4;
  localparam op_t OP_PC_Z = 4'd5;
  localparam op_t OP_TT   = 4'd6;
  localparam op_t OP_DD   = 4'd7;
  localparam op_t OP_TS   = 4'd8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic diff;
    logic mac;
    logic last_dig;
    logic update;
    logic test;
    op_t  op;
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/trajectory_oscillation_detector.sv
// A point with two earlier points in its sequence passes through load, differences,
// the multiply steps of the 16-bit digit-serial multiply-accumulate unit and update;
// the first two points of a sequence skip the multiply steps.
// One point in flight at a time: a new point is taken only once the last is through,
// and is taken while a result waits; the update stalls until the output register is free.
// Synchronous active-low reset clears control, sequence status and loads register defaults.
`default_nettype none
module trajectory_oscillation_detector #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  wire logic                          in_first,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic                               out_inversion,
  output logic [tod_pkg::RUN_W-1:0]          out_run_count,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tod_pkg::THR_W-1:0]     cfg_data
);
  import tod_pkg::*;

  localparam int ND_D  = (2 * COORD_WIDTH + 2 + 15) / 16;
  localparam int NDMAX = (ND_D > 3) ? ND_D : 3;
  localparam int DIG_W = $clog2(NDMAX);

  localparam logic [THR_W-1:0] THR_RESET   = THR_W'(-58982);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(10);

  logic [THR_W-1:0] threshold_r;
  logic [LIM_W-1:0] osc_limit_r;
  dp_cmd_t          cmd;
  logic [DIG_W-1:0] mac_dig;
  logic             test_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_RESET;
      osc_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_data;
        REG_OSC_LIMIT: osc_limit_r <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

  // sequencer
  tod_ctrl #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .test_ready (test_ready),
    .cmd        (cmd),
    .mac_dig    (mac_dig)
  );

  // arithmetic and state
  tod_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .mac_dig    (mac_dig),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pos_z      (in_pos_z),
    .first      (in_first),
    .threshold  (threshold_r),
    .osc_limit  (osc_limit_r),
    .test_ready (test_ready),
    .found      (out_found),
    .inversion  (out_inversion),
    .run_count  (out_run_count)
  );

endmodule
`default_nettype wire

// File: rtl/tod_ctrl.sv
// controller state machine: sequences load, differences, multiply steps and update
`default_nettype none
module tod_ctrl #(
  parameter int COORD_WIDTH = 32,
  localparam int ND_C  = (COORD_WIDTH + 15) / 16,
  localparam int ND_D  = (2 * COORD_WIDTH + 2 + 15) / 16,
  localparam int NDMAX = (ND_D > 3) ? ND_D : 3,
  localparam int DIG_W = $clog2(NDMAX)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire logic             test_ready,
  output tod_pkg::dp_cmd_t      cmd,
  output logic [DIG_W-1:0]      mac_dig
);
  import tod_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIFF = 2'd1;
  localparam logic [1:0] S_MAC  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DIG_W-1:0] dig_last;
  logic             is_last;

  // last digit index of the current operation
  always_comb begin
    unique case (op_r)
      OP_PP_X, OP_PP_Y, OP_PP_Z,
      OP_PC_X, OP_PC_Y, OP_PC_Z: dig_last = DIG_W'(ND_C - 1);
      OP_TT:                     dig_last = DIG_W'(ND_T - 1);
      OP_DD:                     dig_last = DIG_W'(ND_D - 1);
      OP_TS:                     dig_last = DIG_W'(ND_T2 - 1);
      default:                   dig_last = '0;
    endcase
  end

  assign is_last = (dig_r == dig_last);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.last_dig  = is_last;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        op_nxt   = OP_PP_X;
        dig_nxt  = '0;
        state_nxt = test_ready ? S_MAC : S_UPD;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (is_last) begin
          dig_nxt = '0;
          if (op_r == OP_TS) begin
            state_nxt = S_UPD;
          end else begin
            op_nxt = op_r + 4'd1;
          end
        end else begin
          dig_nxt = dig_r + DIG_W'(1);
        end
      end
      S_UPD: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.update    = 1'b1;
          cmd.test      = test_ready;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  assign mac_dig   = dig_r;
  assign out_valid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PP_X;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tod_datapath.sv
// datapath: point history, digit-serial multiply-accumulate, inversion test, run counter
`default_nettype none
module tod_datapath #(
  parameter int COORD_WIDTH = 32,
  localparam int ND_D  = (2 * COORD_WIDTH + 2 + 15) / 16,
  localparam int NDMAX = (ND_D > 3) ? ND_D : 3,
  localparam int DIG_W = $clog2(NDMAX)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  tod_pkg::dp_cmd_t                   cmd,
  input  wire logic [DIG_W-1:0]              mac_dig,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic                          first,
  input  wire logic [tod_pkg::THR_W-1:0]     threshold,
  input  wire logic [tod_pkg::LIM_W-1:0]     osc_limit,
  output logic                               test_ready,
  output logic                               found,
  output logic                               inversion,
  output logic [tod_pkg::RUN_W-1:0]          run_count
);
  import tod_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = 2 * CW + 2;
  localparam int BW     = NDMAX * DIGIT_W;
  localparam int PPW    = AW + DIGIT_W;
  localparam int PW_DD  = 4 * CW + 4;
  localparam int PW_TS  = AW + T2_W;
  localparam int PW     = (PW_DD > PW_TS) ? PW_DD : PW_TS;
  localparam int ACC_W  = PW + 1;

  // point history
  logic signed [CW-1:0] pt_r     [3];
  logic signed [CW-1:0] last_r   [3];
  logic signed [CW-1:0] before_r [3];
  logic [1:0]           seen_r;

  // step vectors as sign and magnitude
  logic [CW-1:0] p_mag_r [3];
  logic [CW-1:0] c_mag_r [3];
  logic          p_neg_r [3];
  logic          c_neg_r [3];

  // products and sums
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [AW-1:0]           s_r;
  logic signed [AW:0]      d_r;
  logic [AW-1:0]           d_mag_r;
  logic [T2_W-1:0]         t2_r;
  logic [PW-1:0]           d2_r;
  logic [PW-1:0]           ts_r;

  // sequence status
  logic             prev_inv_r;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             found_r, found_nxt, prev_inv_nxt;

  // output register
  logic             out_found_r;
  logic             out_inv_r;
  logic [RUN_W-1:0] out_run_r;

  logic [TMAG_W-1:0]       t_mag;
  logic                    t_neg;
  logic [AW-1:0]           a_op;
  logic [BW-1:0]           b_op;
  logic [DIGIT_W-1:0]      b_dig;
  logic [PPW-1:0]          pp;
  logic signed [ACC_W-1:0] term;
  logic                    sub;
  logic                    store;
  logic                    inv_w;

  assign t_neg      = threshold[THR_W-1];
  assign t_mag      = t_neg ? TMAG_W'(-threshold) : TMAG_W'(threshold);
  assign test_ready = (seen_r == 2'd2);

  // operand selection per operation
  always_comb begin
    sub = 1'b0;
    unique case (cmd.op)
      OP_PP_X: begin a_op = AW'(p_mag_r[0]); b_op = BW'(p_mag_r[0]); end
      OP_PP_Y: begin a_op = AW'(p_mag_r[1]); b_op = BW'(p_mag_r[1]); end
      OP_PP_Z: begin a_op = AW'(p_mag_r[2]); b_op = BW'(p_mag_r[2]); end
      OP_PC_X: begin
        a_op = AW'(p_mag_r[0]); b_op = BW'(c_mag_r[0]); sub = p_neg_r[0] ^ c_neg_r[0];
      end
      OP_PC_Y: begin
        a_op = AW'(p_mag_r[1]); b_op = BW'(c_mag_r[1]); sub = p_neg_r[1] ^ c_neg_r[1];
      end
      OP_PC_Z: begin
        a_op = AW'(p_mag_r[2]); b_op = BW'(c_mag_r[2]); sub = p_neg_r[2] ^ c_neg_r[2];
      end
      OP_TT:   begin a_op = AW'(t_mag);      b_op = BW'(t_mag); end
      OP_DD:   begin a_op = d_mag_r;         b_op = BW'(d_mag_r); end
      OP_TS:   begin a_op = s_r;             b_op = BW'(t2_r); end
      default: begin a_op = '0;              b_op = '0; end
    endcase
  end

  // one digit of the multiplier per cycle
  assign b_dig = b_op[DIGIT_W*mac_dig +: DIGIT_W];
  assign pp    = PPW'(a_op) * PPW'(b_dig);
  assign term  = $signed(ACC_W'(pp) << (DIGIT_W * mac_dig));

  always_comb begin
    acc_nxt = sub ? (acc_r - term) : (acc_r + term);
  end

  // a sum is complete at the last digit of these operations
  always_comb begin
    unique case (cmd.op)
      OP_PP_Z, OP_PC_Z, OP_TT, OP_DD, OP_TS: store = cmd.last_dig;
      default:                                store = 1'b0;
    endcase
  end

  // inversion test on the finished products
  always_comb begin
    if (s_r == '0) begin
      inv_w = 1'b0;
    end else if (t_neg) begin
      inv_w = d_r[AW] && (ts_r < d2_r);
    end else begin
      inv_w = d_r[AW] || (d2_r < ts_r);
    end
  end

  // run counter and sticky flag
  always_comb begin
    run_nxt      = run_r;
    found_nxt    = found_r;
    prev_inv_nxt = prev_inv_r;
    if (cmd.test) begin
      prev_inv_nxt = inv_w;
      if (prev_inv_r && inv_w) begin
        if (run_r > osc_limit) begin
          found_nxt = 1'b1;
        end
        if (run_r != RUN_MAX) begin
          run_nxt = run_r + RUN_W'(1);
        end
      end else begin
        run_nxt = '0;
      end
    end
  end

  // sequence status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 2'd0;
      prev_inv_r <= 1'b0;
      run_r      <= '0;
      found_r    <= 1'b0;
    end else if (cmd.load && first) begin
      seen_r     <= 2'd0;
      prev_inv_r <= 1'b0;
      run_r      <= '0;
      found_r    <= 1'b0;
    end else if (cmd.update) begin
      if (seen_r != 2'd2) begin
        seen_r <= seen_r + 2'd1;
      end
      prev_inv_r <= prev_inv_nxt;
      run_r      <= run_nxt;
      found_r    <= found_nxt;
    end
  end

  // point history and step vectors
  always_ff @(posedge clk) begin
    logic signed [CW:0] dp;
    logic signed [CW:0] dc;
    for (int k = 0; k < 3; k++) begin
      dp = {last_r[k][CW-1], last_r[k]} - {before_r[k][CW-1], before_r[k]};
      dc = {pt_r[k][CW-1], pt_r[k]} - {last_r[k][CW-1], last_r[k]};
      if (cmd.diff) begin
        p_neg_r[k] <= dp[CW];
        c_neg_r[k] <= dc[CW];
        p_mag_r[k] <= dp[CW] ? CW'(-dp) : CW'(dp);
        c_mag_r[k] <= dc[CW] ? CW'(-dc) : CW'(dc);
      end
      if (cmd.update) begin
        before_r[k] <= last_r[k];
        last_r[k]   <= pt_r[k];
      end
    end
    if (cmd.load) begin
      pt_r[0] <= pos_x;
      pt_r[1] <= pos_y;
      pt_r[2] <= pos_z;
    end
  end

  // accumulator and finished sums
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= store ? '0 : acc_nxt;
      if (store) begin
        unique case (cmd.op)
          OP_PP_Z: s_r  <= AW'(acc_nxt);
          OP_PC_Z: d_r  <= (AW+1)'(acc_nxt);
          OP_TT:   t2_r <= T2_W'(acc_nxt);
          OP_DD:   d2_r <= PW'(acc_nxt);
          OP_TS:   ts_r <= PW'(acc_nxt);
          default: ;
        endcase
      end
    end
    // magnitude of the dot product, ready before its square is taken
    d_mag_r <= d_r[AW] ? AW'(-d_r) : AW'(d_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_found_r <= found_nxt;
      out_inv_r   <= cmd.test && inv_w;
      out_run_r   <= run_nxt;
    end
  end

  assign found     = out_found_r;
  assign inversion = out_inv_r;
  assign run_count = out_run_r;

endmodule
`default_nettype wire
